// ===== hw/rtl/imus_pkg.sv =====
package imus_pkg;

    // raw sample format
    localparam int RAW_W = 16;
    localparam int N_AXES = 3;

    // stream payload widths
    localparam int IN_TDATA_W  = 160;
    localparam int OUT_TDATA_W = 184;

    // result field widths
    localparam int ACC_OUT_W  = 15;
    localparam int GYRO_OUT_W = 19;
    localparam int MAG_OUT_W  = 21;
    localparam int TEMP_OUT_W = 15;

    // internal product widths
    localparam int ACC_PROD_W  = 26;
    localparam int GYRO_MAG_W  = 25;
    localparam int TEMP_PROD_W = 30;
    localparam int MAG_PROD_W  = 25;
    localparam int MAG_SCL_W   = 29;
    localparam int ADJ_W       = 9;

    // conversion constants
    localparam int ACC_SCALE     = 1000;
    localparam int GYRO_SCALE    = 1000;
    localparam int TEMP_SCALE    = 10000;
    localparam int TEMP_DIVISOR  = 33387;
    localparam int TEMP_OFFSET   = 2100;
    localparam int MAG_SCALE_LOG = 4;   // x15 done as x16 minus x1
    localparam int MAG_DIV_LOG   = 8;   // divide by 256
    localparam int ACC_SHIFT_MAX = 14;  // 2g sensitivity is 16384 = 2**14
    localparam int ADJ_RESET     = 256;

    // shared divider
    localparam int DIV_DVD_W  = 32;
    localparam int DIV_DVS_W  = 16;
    localparam int DIV_RADIX  = 4;
    localparam int DIV_STEPS  = DIV_DVD_W / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_RANGE = 3'd0,
        CFG_GYRO_RANGE  = 3'd1,
        CFG_MAG_ADJ_X   = 3'd2,
        CFG_MAG_ADJ_Y   = 3'd3,
        CFG_MAG_ADJ_Z   = 3'd4,
        CFG_MAG_PRESENT = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        JOB_GYRO_X = 2'd0,
        JOB_GYRO_Y = 2'd1,
        JOB_GYRO_Z = 2'd2,
        JOB_TEMP   = 2'd3
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_store;
        logic out_load;
        job_t job;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
        logic mag_avail;
    } stat_t;

    // gyro sensitivity in lsb per dps, times ten
    function automatic logic [DIV_DVS_W-1:0] gyro_sens(input logic [1:0] sel);
        logic [DIV_DVS_W-1:0] s;
        unique case (sel)
            2'd0:    s = 16'd1310;
            2'd1:    s = 16'd655;
            2'd2:    s = 16'd328;
            default: s = 16'd164;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/imus_div.sv =====
module imus_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [imus_pkg::DIV_DVD_W-1:0]   dividend,
    input  logic [imus_pkg::DIV_DVS_W-1:0]   divisor,
    output logic                             done,
    output logic [imus_pkg::DIV_DVD_W-1:0]   quotient
);
    import imus_pkg::*;

    logic [DIV_DVD_W-1:0] quo_reg, quo_next;
    logic [DIV_DVS_W:0]   rem_reg, rem_next;
    logic [DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_DVS_W:0]   step_rem;
    logic [DIV_DVD_W-1:0] step_quo;

    // restoring division, DIV_RADIX quotient bits per cycle
    always_comb begin
        step_rem = rem_reg;
        step_quo = quo_reg;
        for (int k = 0; k < DIV_RADIX; k++) begin
            step_rem = {step_rem[DIV_DVS_W-1:0], step_quo[DIV_DVD_W-1]};
            step_quo = {step_quo[DIV_DVD_W-2:0], 1'b0};
            if (step_rem >= {1'b0, dvs_reg}) begin
                step_rem = step_rem - {1'b0, dvs_reg};
                step_quo[0] = 1'b1;
            end
        end
    end

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = step_quo;
            rem_next = step_rem;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hw/rtl/imus_dp.sv =====
module imus_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [imus_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imus_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [imus_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [imus_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  imus_pkg::cmd_t                      cmd,
    output imus_pkg::stat_t                     stat
);
    import imus_pkg::*;

    // configuration
    logic [1:0]       accel_sel_reg, accel_sel_next;
    logic [1:0]       gyro_sel_reg, gyro_sel_next;
    logic [ADJ_W-1:0] adj_reg [N_AXES];
    logic [ADJ_W-1:0] adj_next [N_AXES];
    logic             mag_present_reg, mag_present_next;
    logic             mag_avail_reg, mag_avail_next;

    // products taken at acceptance
    logic signed [ACC_PROD_W-1:0] acc_prod_reg [N_AXES];
    logic signed [ACC_PROD_W-1:0] acc_prod_next [N_AXES];
    logic [GYRO_MAG_W-1:0]        gyro_abs_reg [N_AXES];
    logic [GYRO_MAG_W-1:0]        gyro_abs_next [N_AXES];
    logic [N_AXES-1:0]            gyro_neg_reg, gyro_neg_next;
    logic [TEMP_PROD_W-2:0]       temp_abs_reg, temp_abs_next;
    logic                         temp_neg_reg, temp_neg_next;
    logic signed [MAG_PROD_W-1:0] mag_prod_reg [N_AXES];
    logic signed [MAG_PROD_W-1:0] mag_prod_next [N_AXES];
    logic                         mag_use_reg, mag_use_next;

    // division results
    logic signed [GYRO_OUT_W-1:0] gyro_res_reg [N_AXES];
    logic signed [GYRO_OUT_W-1:0] gyro_res_next [N_AXES];
    logic signed [TEMP_OUT_W-1:0] temp_res_reg, temp_res_next;

    // output stage
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    // divider hookup
    logic [DIV_DVD_W-1:0] div_dvd;
    logic [DIV_DVS_W-1:0] div_dvs;
    logic                 div_done;
    logic [DIV_DVD_W-1:0] div_quo;

    // per-item working values
    logic signed [RAW_W-1:0]          raw_acc [N_AXES];
    logic signed [RAW_W-1:0]          raw_gyro [N_AXES];
    logic signed [RAW_W-1:0]          raw_mag [N_AXES];
    logic signed [RAW_W-1:0]          raw_temp;
    logic signed [ACC_PROD_W-1:0]     gyro_prod [N_AXES];
    logic signed [TEMP_PROD_W-1:0]    temp_prod;
    logic signed [ACC_OUT_W-1:0]      acc_out [N_AXES];
    logic signed [MAG_OUT_W-1:0]      mag_out [N_AXES];
    logic [GYRO_OUT_W-1:0]            q_gyro;
    logic [TEMP_OUT_W-1:0]            q_temp;

    // raw * 1000 divided by a power-of-two sensitivity, toward zero
    function automatic logic signed [ACC_OUT_W-1:0] acc_scale(
        input logic signed [ACC_PROD_W-1:0] p,
        input logic [1:0]                   sel
    );
        logic [4:0]                   sh;
        logic signed [ACC_PROD_W-1:0] bias;
        logic signed [ACC_PROD_W-1:0] sum;
        sh   = 5'(ACC_SHIFT_MAX) - {3'b000, sel};
        bias = p[ACC_PROD_W-1] ? $signed((ACC_PROD_W'(1) << sh) - ACC_PROD_W'(1)) : '0;
        sum  = p + bias;
        return ACC_OUT_W'(sum >>> sh);
    endfunction

    // raw * adjust * 15 / 256, toward zero
    function automatic logic signed [MAG_OUT_W-1:0] mag_scale(
        input logic signed [MAG_PROD_W-1:0] p
    );
        logic signed [MAG_SCL_W-1:0] x;
        logic signed [MAG_SCL_W-1:0] bias;
        x    = $signed({{(MAG_SCL_W-MAG_PROD_W){p[MAG_PROD_W-1]}}, p});
        x    = (x <<< MAG_SCALE_LOG) - x;
        bias = x[MAG_SCL_W-1] ? MAG_SCL_W'((1 << MAG_DIV_LOG) - 1) : '0;
        return MAG_OUT_W'((x + bias) >>> MAG_DIV_LOG);
    endfunction

    // field extraction
    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            raw_acc[i]  = $signed(s_tdata[i*RAW_W +: RAW_W]);
            raw_gyro[i] = $signed(s_tdata[(4+i)*RAW_W +: RAW_W]);
            raw_mag[i]  = $signed(s_tdata[(7+i)*RAW_W +: RAW_W]);
        end
        raw_temp = $signed(s_tdata[3*RAW_W +: RAW_W]);
    end

    // configuration writes and sticky magnetometer state
    always_comb begin
        accel_sel_next   = accel_sel_reg;
        gyro_sel_next    = gyro_sel_reg;
        adj_next         = adj_reg;
        mag_present_next = mag_present_reg;
        mag_avail_next   = mag_avail_reg;
        if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ACCEL_RANGE: accel_sel_next   = cfg_wdata[1:0];
                CFG_GYRO_RANGE:  gyro_sel_next    = cfg_wdata[1:0];
                CFG_MAG_ADJ_X:   adj_next[0]      = cfg_wdata;
                CFG_MAG_ADJ_Y:   adj_next[1]      = cfg_wdata;
                CFG_MAG_ADJ_Z:   adj_next[2]      = cfg_wdata;
                CFG_MAG_PRESENT: mag_present_next = cfg_wdata[0];
                default:         ;
            endcase
        end
        if (cmd.load && mag_present_reg && mag_avail_reg && !s_tuser) begin
            mag_avail_next = 1'b0;
        end
    end

    // multiplications at acceptance
    always_comb begin
        acc_prod_next = acc_prod_reg;
        gyro_abs_next = gyro_abs_reg;
        gyro_neg_next = gyro_neg_reg;
        temp_abs_next = temp_abs_reg;
        temp_neg_next = temp_neg_reg;
        mag_prod_next = mag_prod_reg;
        mag_use_next  = mag_use_reg;
        for (int i = 0; i < N_AXES; i++) begin
            gyro_prod[i] = $signed({{(ACC_PROD_W-RAW_W){raw_gyro[i][RAW_W-1]}}, raw_gyro[i]})
                         * $signed(ACC_PROD_W'(GYRO_SCALE));
        end
        temp_prod = $signed({{(TEMP_PROD_W-RAW_W){raw_temp[RAW_W-1]}}, raw_temp})
                  * $signed(TEMP_PROD_W'(TEMP_SCALE));
        if (cmd.load) begin
            for (int i = 0; i < N_AXES; i++) begin
                acc_prod_next[i] =
                    $signed({{(ACC_PROD_W-RAW_W){raw_acc[i][RAW_W-1]}}, raw_acc[i]})
                    * $signed(ACC_PROD_W'(ACC_SCALE));
                gyro_neg_next[i] = gyro_prod[i][ACC_PROD_W-1];
                gyro_abs_next[i] = GYRO_MAG_W'(gyro_prod[i][ACC_PROD_W-1] ?
                                               -gyro_prod[i] : gyro_prod[i]);
                mag_prod_next[i] =
                    $signed({{(MAG_PROD_W-RAW_W){raw_mag[i][RAW_W-1]}}, raw_mag[i]})
                    * $signed({{(MAG_PROD_W-ADJ_W){1'b0}}, adj_reg[i]});
            end
            temp_neg_next = temp_prod[TEMP_PROD_W-1];
            temp_abs_next = (TEMP_PROD_W-1)'(temp_prod[TEMP_PROD_W-1] ? -temp_prod : temp_prod);
            mag_use_next  = mag_present_reg && mag_avail_reg && s_tuser;
        end
    end

    // divider operand select
    always_comb begin
        unique case (cmd.job)
            JOB_GYRO_X: div_dvd = DIV_DVD_W'(gyro_abs_reg[0]);
            JOB_GYRO_Y: div_dvd = DIV_DVD_W'(gyro_abs_reg[1]);
            JOB_GYRO_Z: div_dvd = DIV_DVD_W'(gyro_abs_reg[2]);
            default:    div_dvd = DIV_DVD_W'(temp_abs_reg);
        endcase
        div_dvs = (cmd.job == JOB_TEMP) ? DIV_DVS_W'(TEMP_DIVISOR) : gyro_sens(gyro_sel_reg);
    end

    imus_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    // signs put back on the quotients, plus the temperature offset
    always_comb begin
        gyro_res_next = gyro_res_reg;
        temp_res_next = temp_res_reg;
        q_gyro        = div_quo[GYRO_OUT_W-1:0];
        q_temp        = div_quo[TEMP_OUT_W-1:0];
        if (cmd.div_store) begin
            case (cmd.job)
                JOB_GYRO_X: gyro_res_next[0] = $signed(gyro_neg_reg[0] ? -q_gyro : q_gyro);
                JOB_GYRO_Y: gyro_res_next[1] = $signed(gyro_neg_reg[1] ? -q_gyro : q_gyro);
                JOB_GYRO_Z: gyro_res_next[2] = $signed(gyro_neg_reg[2] ? -q_gyro : q_gyro);
                default:    temp_res_next = $signed((temp_neg_reg ? -q_temp : q_temp)
                                                    + TEMP_OUT_W'(TEMP_OFFSET));
            endcase
        end
    end

    // output stage
    always_comb begin
        for (int i = 0; i < N_AXES; i++) begin
            acc_out[i] = acc_scale(acc_prod_reg[i], accel_sel_reg);
            mag_out[i] = mag_use_reg ? mag_scale(mag_prod_reg[i]) : '0;
        end
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg;
        if (cmd.out_load) begin
            m_tdata_next  = {4'b0000, temp_res_reg,
                             mag_out[2], mag_out[1], mag_out[0],
                             gyro_res_reg[2], gyro_res_reg[1], gyro_res_reg[0],
                             acc_out[2], acc_out[1], acc_out[0]};
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_sel_reg   <= '0;
            gyro_sel_reg    <= '0;
            for (int i = 0; i < N_AXES; i++) begin
                adj_reg[i] <= ADJ_W'(ADJ_RESET);
            end
            mag_present_reg <= 1'b0;
            mag_avail_reg   <= 1'b1;
            m_tvalid_reg    <= 1'b0;
        end else begin
            accel_sel_reg   <= accel_sel_next;
            gyro_sel_reg    <= gyro_sel_next;
            adj_reg         <= adj_next;
            mag_present_reg <= mag_present_next;
            mag_avail_reg   <= mag_avail_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_prod_reg <= acc_prod_next;
        gyro_abs_reg <= gyro_abs_next;
        gyro_neg_reg <= gyro_neg_next;
        temp_abs_reg <= temp_abs_next;
        temp_neg_reg <= temp_neg_next;
        mag_prod_reg <= mag_prod_next;
        mag_use_reg  <= mag_use_next;
        gyro_res_reg <= gyro_res_next;
        temp_res_reg <= temp_res_next;
        m_tdata_reg  <= m_tdata_next;
    end

    assign m_tvalid       = m_tvalid_reg;
    assign m_tdata        = m_tdata_reg;
    assign stat.div_done  = div_done;
    assign stat.out_free  = !m_tvalid_reg || m_tready;
    assign stat.mag_avail = mag_avail_reg;

endmodule

// ===== hw/rtl/imus_ctrl.sv =====
module imus_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  imus_pkg::stat_t   stat,
    output imus_pkg::cmd_t    cmd
);
    import imus_pkg::*;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DIV_START;
                    job_next   = JOB_GYRO_X;
                end
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (stat.div_done) begin
                    job_next   = job_t'(job_reg + 2'd1);
                    state_next = (job_reg == JOB_TEMP) ? ST_DONE : ST_DIV_START;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.div_start = 1'b0;
        cmd.div_store = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.job       = job_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV_WAIT:  cmd.div_store = stat.div_done;
            ST_DONE:      cmd.out_load  = stat.out_free;
            default:      ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_GYRO_X;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
        end
    end

endmodule

// ===== hw/rtl/imu_raw_to_units_scaler.sv =====
// imu raw-to-units scaler: takes one full set of raw imu readings per transaction and
// returns one transaction with accel in mg, gyro in dps x100, magnetometer in uT x100 and
// temperature in degC x100, all divisions truncating toward zero. accel scaling is a
// rounding-corrected shift, magnetometer scaling a multiply by the per-axis adjust value,
// and the three gyro axes plus temperature go one after another through a single shared
// divider that resolves four quotient bits a cycle. a new item is accepted only once the
// previous one has been through all four divisions and handed off; the result
// sits in an output register, so the next item is taken and worked on while the previous
// result waits for m_tready. a magnetometer reading flagged bad while the magnetometer is
// enabled zeroes the mag fields and disables the magnetometer until reset. the user must
// write configuration registers only while the block is idle; this is not enforced.
module imu_raw_to_units_scaler (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [imus_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imus_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // raw sample stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, temp_raw, gyro_x_raw, gyro_y_raw,
    // gyro_z_raw, mag_x_raw, mag_y_raw, mag_z_raw (16 bits each)
    input  logic [imus_pkg::IN_TDATA_W-1:0]     s_tdata,
    // mag_ok
    input  logic                                s_tuser,
    // scaled result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // accel_x_mg, accel_y_mg, accel_z_mg (15 each), gyro_x_cdps, gyro_y_cdps,
    // gyro_z_cdps (19 each), mag_x_cut, mag_y_cut, mag_z_cut (21 each),
    // temp_cdeg (15), 4 zero pad bits
    output logic [imus_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import imus_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // register writes are always accepted; cfg_ready is tied high
    assign cfg_ready = 1'b1;

    // sequencer: accept, four divisions, hand off to output register
    imus_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: config registers, multipliers, shared divider, output register
    imus_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    // once the magnetometer is disabled only reset brings it back
    assert property (@(posedge aclk) disable iff (!aresetn)
        !stat.mag_avail |=> !stat.mag_avail)
        else $error("magnetometer availability came back without reset");

    // a finished result never overwrites one still waiting at the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("output register overwritten while holding a result");

    // quotients are only stored when the divider reports completion
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_store |-> stat.div_done)
        else $error("quotient stored before divider finished");

endmodule
